/* src/wrad_pkg.sv */
// package: shared types and constants of the wavelet rate anomaly detector
package wrad_pkg;

  localparam int AVG_W = 32;
  localparam int DET_W = 33;
  localparam int SCORE_W = 32;
  localparam int INV_W = 32;
  localparam int CFG_W = 33;
  localparam int CFG_INDEX_W = 3;
  localparam int TAP_W = 16;
  localparam int TAPS = 4;
  localparam int PROD_W = DET_W + INV_W;
  localparam int FRAC_SHIFT = 16;
  localparam int DETAIL_SHIFT = 7;
  localparam int MEAN_SHIFT = 8;

  typedef logic signed [TAP_W-1:0] tap_t;
  localparam tap_t D4_TAP [TAPS] = '{-16'sd4240, -16'sd7345, 16'sd27411, -16'sd15826};

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_AVG_MEDIAN     = 3'd0,
    REG_AVG_INV_SIGMA  = 3'd1,
    REG_MEAN_THRESHOLD = 3'd2,
    REG_DET_MEDIAN     = 3'd3,
    REG_DET_INV_SIGMA  = 3'd4,
    REG_DET_THRESHOLD  = 3'd5
  } reg_index_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_DIVIDE,
    S_PREP,
    S_SCORE,
    S_FINISH
  } state_t;

endpackage

/* src/wrad_if.sv */
// interfaces: sample input channel and result output channel
interface wrad_sample_if #(parameter int SAMPLE_WIDTH = 24);
  logic valid;
  logic ready;
  logic [SAMPLE_WIDTH-1:0] sample_value;
  modport source (output valid, output sample_value, input ready);
  modport sink (input valid, input sample_value, output ready);
endinterface

interface wrad_result_if;
  import wrad_pkg::*;
  logic valid;
  logic ready;
  logic [AVG_W-1:0] rolling_average;
  logic signed [SCORE_W-1:0] average_score;
  logic [DET_W-1:0] wavelet_detail;
  logic signed [SCORE_W-1:0] wavelet_score;
  logic average_alert;
  logic wavelet_alert;
  modport source (output valid, output rolling_average, output average_score,
                  output wavelet_detail, output wavelet_score, output average_alert,
                  output wavelet_alert, input ready);
  modport sink (input valid, input rolling_average, input average_score,
                input wavelet_detail, input wavelet_score, input average_alert,
                input wavelet_alert, output ready);
endinterface

/* src/wavelet_rate_anomaly_detector_unit.sv */
// top level: rolling mean, D4 detail and robust z-score detector
//
// channel   | dir | transfer when         | payload
// samples   | in  | valid && ready        | sample_value
// results   | out | valid && ready        | mean, detail, two scores, two alerts
// cfg       | in  | cfg_write_enable high | cfg_index, cfg_data
//
// one sample is processed serially, in these steps:
// the restoring divider for the mean gives one quotient bit a cycle, then the two
// shift-add score multipliers take one bit of inverse sigma a cycle.
// the D4 taps run one per cycle alongside the divider.
// samples.ready is high only while idle; a finished result waits in the output register
// and the next sample is taken meanwhile.
// reset is synchronous; the window needs no clearing pass, the fill count masks it.
module wavelet_rate_anomaly_detector_unit #(
  parameter int WINDOW_LENGTH = 16,
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic clk,
  input  logic rst,
  wrad_sample_if.sink samples,
  wrad_result_if.source results,
  input  logic cfg_write_enable,
  input  logic [wrad_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wrad_pkg::CFG_W-1:0] cfg_data
);
  import wrad_pkg::*;

  localparam int POS_W = $clog2(WINDOW_LENGTH);
  localparam int FILL_W = $clog2(WINDOW_LENGTH + 1);
  localparam int SUM_W = SAMPLE_WIDTH + POS_W;
  localparam int QW = SUM_W + MEAN_SHIFT;
  localparam int QCNT_W = $clog2(QW);
  localparam int ACC_W = SAMPLE_WIDTH + 18;
  localparam int MAG_W = ACC_W - DETAIL_SHIFT;
  localparam int BIT_W = $clog2(INV_W);
  localparam int STEP_W = 3;

  // configuration
  logic [AVG_W-1:0] avg_median;
  logic [INV_W-1:0] avg_inverse_sigma;
  logic [SCORE_W-1:0] mean_threshold;
  logic [DET_W-1:0] detail_median;
  logic [INV_W-1:0] detail_inverse_sigma;
  logic [SCORE_W-1:0] detail_threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_median <= '0;
      avg_inverse_sigma <= INV_W'(65536);
      mean_threshold <= SCORE_W'(2048);
      detail_median <= '0;
      detail_inverse_sigma <= INV_W'(65536);
      detail_threshold <= SCORE_W'(2048);
    end else if (cfg_write_enable) begin
      case (cfg_index)
        REG_AVG_MEDIAN:     avg_median <= cfg_data[AVG_W-1:0];
        REG_AVG_INV_SIGMA:  avg_inverse_sigma <= cfg_data[INV_W-1:0];
        REG_MEAN_THRESHOLD: mean_threshold <= cfg_data[SCORE_W-1:0];
        REG_DET_MEDIAN:     detail_median <= cfg_data[DET_W-1:0];
        REG_DET_INV_SIGMA:  detail_inverse_sigma <= cfg_data[INV_W-1:0];
        REG_DET_THRESHOLD:  detail_threshold <= cfg_data[SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  state_t state, state_next;
  logic in_take, out_load;

  logic [SAMPLE_WIDTH-1:0] window_mem [WINDOW_LENGTH];
  logic [SAMPLE_WIDTH-1:0] old_sample;
  logic [SAMPLE_WIDTH-1:0] sample_reg;
  logic [SUM_W-1:0] window_sum;
  logic [FILL_W-1:0] fill_count;
  logic [POS_W-1:0] write_position;

  logic [SAMPLE_WIDTH-1:0] tap_line [TAPS];
  logic [1:0] tap_count;
  logic det_on;
  logic [STEP_W-1:0] tap_step;
  logic signed [ACC_W-2:0] tap_prod;
  logic signed [ACC_W-1:0] tap_acc;

  logic [QW-1:0] div_reg;
  logic [FILL_W-1:0] div_rem;
  logic [QCNT_W-1:0] div_cnt;

  logic [AVG_W-1:0] avg_reg;
  logic [DET_W-1:0] det_reg;
  logic [DET_W-1:0] mag_a, mag_d;
  logic neg_a, neg_d;
  logic [PROD_W-1:0] acc_a, acc_d;
  logic [INV_W-1:0] inv_a, inv_d;
  logic [BIT_W-1:0] bit_cnt;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (samples.valid) state_next = S_READ;
      S_READ:   state_next = S_DIVIDE;
      S_DIVIDE: if (div_cnt == QCNT_W'(QW - 1)) state_next = S_PREP;
      S_PREP:   state_next = S_SCORE;
      S_SCORE:  if (bit_cnt == BIT_W'(INV_W - 1)) state_next = S_FINISH;
      S_FINISH: if (!results.valid || results.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    samples.ready = 1'b0;
    out_load = 1'b0;
    unique case (state)
      S_IDLE:   samples.ready = 1'b1;
      S_FINISH: out_load = !results.valid || results.ready;
      default: ;
    endcase
  end

  assign in_take = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // window memory with registered read
  always_ff @(posedge clk) begin
    old_sample <= window_mem[write_position];
    if (state == S_READ) window_mem[write_position] <= sample_reg;
  end

  // divider step
  logic [FILL_W:0] rem_shift;
  logic rem_ge;
  logic [FILL_W:0] rem_diff;
  logic [SUM_W-1:0] sum_next;
  always_comb begin
    rem_shift = {div_rem, div_reg[QW-1]};
    rem_ge = rem_shift >= {1'b0, fill_count};
    rem_diff = rem_shift - {1'b0, fill_count};
    sum_next = window_sum + SUM_W'(sample_reg)
             - ((fill_count == FILL_W'(WINDOW_LENGTH)) ? SUM_W'(old_sample) : SUM_W'(0));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum <= '0;
      fill_count <= '0;
      write_position <= '0;
      tap_count <= '0;
    end else begin
      if (in_take && tap_count != 2'd3) tap_count <= tap_count + 2'd1;
      if (state == S_READ) begin
        window_sum <= sum_next;
        if (fill_count != FILL_W'(WINDOW_LENGTH)) fill_count <= fill_count + FILL_W'(1);
        write_position <= (write_position == POS_W'(WINDOW_LENGTH - 1))
                          ? '0 : write_position + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      sample_reg <= samples.sample_value;
      det_on <= (tap_count == 2'd3);
      for (int k = 0; k < TAPS - 1; k++) tap_line[k] <= tap_line[k+1];
      tap_line[TAPS-1] <= samples.sample_value;
    end
    unique case (state)
      S_READ: begin
        div_reg <= {sum_next, MEAN_SHIFT'(0)};
        div_rem <= '0;
        div_cnt <= '0;
        tap_step <= '0;
        tap_acc <= '0;
      end
      S_DIVIDE: begin
        div_reg <= {div_reg[QW-2:0], rem_ge};
        div_rem <= rem_ge ? rem_diff[FILL_W-1:0] : rem_shift[FILL_W-1:0];
        div_cnt <= div_cnt + QCNT_W'(1);
        if (tap_step < STEP_W'(TAPS))
          tap_prod <= $signed({1'b0, tap_line[tap_step[1:0]]}) * D4_TAP[tap_step[1:0]];
        if (tap_step != STEP_W'(0) && tap_step <= STEP_W'(TAPS))
          tap_acc <= tap_acc + ACC_W'(tap_prod);
        if (tap_step <= STEP_W'(TAPS)) tap_step <= tap_step + STEP_W'(1);
      end
      default: ;
    endcase
  end

  // feature saturation and deviation from median
  logic [AVG_W+QW-1:0] avg_wide;
  logic [AVG_W-1:0] avg_sat;
  logic [ACC_W-1:0] acc_abs;
  logic [DET_W+MAG_W-1:0] det_wide;
  logic [DET_W-1:0] det_sat;
  logic [DET_W-1:0] feat_a;
  always_comb begin
    avg_wide = {AVG_W'(0), div_reg};
    avg_sat = (|avg_wide[AVG_W+QW-1:AVG_W]) ? '1 : avg_wide[AVG_W-1:0];
    acc_abs = tap_acc[ACC_W-1] ? ACC_W'(-tap_acc) : ACC_W'(tap_acc);
    det_wide = {DET_W'(0), acc_abs[ACC_W-1:DETAIL_SHIFT]};
    det_sat = (|det_wide[DET_W+MAG_W-1:DET_W]) ? '1 : det_wide[DET_W-1:0];
    if (!det_on) det_sat = '0;
    feat_a = DET_W'(avg_sat);
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_PREP: begin
        avg_reg <= avg_sat;
        det_reg <= det_sat;
        neg_a <= feat_a < DET_W'(avg_median);
        mag_a <= (feat_a < DET_W'(avg_median)) ? DET_W'(avg_median) - feat_a
                                               : feat_a - DET_W'(avg_median);
        neg_d <= det_sat < detail_median;
        mag_d <= (det_sat < detail_median) ? detail_median - det_sat
                                           : det_sat - detail_median;
        acc_a <= '0;
        acc_d <= '0;
        inv_a <= avg_inverse_sigma;
        inv_d <= detail_inverse_sigma;
        bit_cnt <= '0;
      end
      S_SCORE: begin
        acc_a <= {acc_a[PROD_W-2:0], 1'b0} + (inv_a[INV_W-1] ? PROD_W'(mag_a) : PROD_W'(0));
        acc_d <= {acc_d[PROD_W-2:0], 1'b0} + (inv_d[INV_W-1] ? PROD_W'(mag_d) : PROD_W'(0));
        inv_a <= {inv_a[INV_W-2:0], 1'b0};
        inv_d <= {inv_d[INV_W-2:0], 1'b0};
        bit_cnt <= bit_cnt + BIT_W'(1);
      end
      default: ;
    endcase
  end

  // sign and saturation of the scores
  localparam int P_W = PROD_W - FRAC_SHIFT;
  logic [P_W-1:0] p_a, p_d;
  logic signed [SCORE_W-1:0] score_a, score_d;
  always_comb begin
    p_a = acc_a[PROD_W-1:FRAC_SHIFT];
    p_d = acc_d[PROD_W-1:FRAC_SHIFT];
    if (neg_a) score_a = (p_a > P_W'(33'h080000000)) ? 32'sh80000000 : -$signed(p_a[31:0]);
    else score_a = (p_a > P_W'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : $signed(p_a[31:0]);
    if (neg_d) score_d = (p_d > P_W'(33'h080000000)) ? 32'sh80000000 : -$signed(p_d[31:0]);
    else score_d = (p_d > P_W'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : $signed(p_d[31:0]);
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      results.rolling_average <= avg_reg;
      results.average_score <= score_a;
      results.wavelet_detail <= det_reg;
      results.wavelet_score <= score_d;
      results.average_alert <= score_a > $signed(mean_threshold);
      results.wavelet_alert <= score_d > $signed(detail_threshold);
    end
  end

endmodule

/* src/wrad_checker.sv */
// checker: port-level properties of the detector, bound to the top level
module wrad_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [31:0] out_average
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_average))
    else $error("stalled result changed");

  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("sample taken while busy");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without work");

endmodule

bind wavelet_rate_anomaly_detector_unit wrad_checker u_wrad_checker (
  .clk(clk),
  .rst(rst),
  .in_valid(samples.valid),
  .in_ready(samples.ready),
  .out_valid(results.valid),
  .out_ready(results.ready),
  .out_average(results.rolling_average)
);
